// ----- hw/rtl/spa_pkg.sv -----
// Shared constants and tables for the scan principal axes block.
`timescale 1ns / 1ps

package spa_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int DIST_W = 16;
    localparam int ANG_W = 16;
    localparam int THR_W = 40;
    localparam int VEC_W = 16;
    localparam int Z_W = 26;
    localparam logic [THR_W-1:0] THR_RESET = 40'd1;
    localparam logic [VEC_W-1:0] UNIT_Q14 = 16'd16384;

    typedef logic signed [Z_W-1:0] angle_t;

    function automatic angle_t atan_lookup(input logic [3:0] idx);
        angle_t val;
        begin
            case (idx)
                4'd0:    val = 26'sd2097152;
                4'd1:    val = 26'sd1238021;
                4'd2:    val = 26'sd654136;
                4'd3:    val = 26'sd332050;
                4'd4:    val = 26'sd166669;
                4'd5:    val = 26'sd83416;
                4'd6:    val = 26'sd41718;
                4'd7:    val = 26'sd20860;
                4'd8:    val = 26'sd10430;
                4'd9:    val = 26'sd5215;
                4'd10:   val = 26'sd2608;
                4'd11:   val = 26'sd1304;
                4'd12:   val = 26'sd652;
                4'd13:   val = 26'sd326;
                4'd14:   val = 26'sd163;
                default: val = 26'sd82;
            endcase
            return val;
        end
    endfunction

endpackage

// ----- hw/rtl/scan_principal_axes_top.sv -----
// Top level of the scan principal axes block: CORDIC, shared multiplier and eigen solver.
`timescale 1ns / 1ps

// Each sample taken while the count is below MAX_SAMPLES keeps busy high through 16 CORDIC
// iterations followed by 7 steps that share one multiplier for the point and its products.
// A sample marked last then runs the solve: a one-bit-per-cycle normalization shift,
// two 30-step square roots, two 16-step divisions and a few multiply steps; the diagonal
// case finishes at the compare step without any of these. A result appears on
// result_valid for exactly one cycle and the receiver cannot stall it, so it must be captured
// at that edge. Configuration is always ready and should be written only while busy is low.
module scan_principal_axes_top #(
    parameter int MAX_SAMPLES = spa_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [spa_pkg::DIST_W-1:0]      distance,
    input  logic [spa_pkg::ANG_W-1:0]       bearing,
    input  logic                            last_sample,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spa_pkg::THR_W-1:0]       cfg_data,
    output logic                            result_valid,
    output logic signed [spa_pkg::VEC_W-1:0] principal_x,
    output logic signed [spa_pkg::VEC_W-1:0] principal_y,
    output logic signed [spa_pkg::VEC_W-1:0] minor_x,
    output logic signed [spa_pkg::VEC_W-1:0] minor_y,
    output logic                            overflowed
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = 35 + CNT_W;
    localparam int HW = SUM_W + 1;
    localparam int CW = (SUM_W > spa_pkg::THR_W) ? SUM_W : spa_pkg::THR_W;
    localparam int SQ_W = 60;
    localparam int RM_W = 46;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CORD = 5'd1;
    localparam logic [4:0] ST_MC   = 5'd2;
    localparam logic [4:0] ST_MS   = 5'd3;
    localparam logic [4:0] ST_MY   = 5'd4;
    localparam logic [4:0] ST_MXX  = 5'd5;
    localparam logic [4:0] ST_MXY  = 5'd6;
    localparam logic [4:0] ST_MYY  = 5'd7;
    localparam logic [4:0] ST_ACC  = 5'd8;
    localparam logic [4:0] ST_SOLV = 5'd9;
    localparam logic [4:0] ST_CMP  = 5'd10;
    localparam logic [4:0] ST_NORM = 5'd11;
    localparam logic [4:0] ST_SQ1  = 5'd12;
    localparam logic [4:0] ST_SQ2  = 5'd13;
    localparam logic [4:0] ST_SQ3  = 5'd14;
    localparam logic [4:0] ST_ROOT = 5'd15;
    localparam logic [4:0] ST_VEC  = 5'd16;
    localparam logic [4:0] ST_DVI  = 5'd17;
    localparam logic [4:0] ST_DIV  = 5'd18;
    localparam logic [4:0] ST_FIN  = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [spa_pkg::THR_W-1:0] thr_reg, thr_next;
    logic [spa_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic last_reg, last_next;
    logic flip_reg, flip_next;
    logic signed [32:0] cx_reg, cx_next, cy_reg, cy_next;
    spa_pkg::angle_t z_reg, z_next;
    logic [4:0] it_reg, it_next;
    logic signed [65:0] prod_reg;
    logic signed [17:0] px_reg, px_next, py_reg, py_next;
    logic signed [SUM_W-1:0] sxx_reg, sxx_next, sxy_reg, sxy_next, syy_reg, syy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic drop_reg, drop_next;
    logic [HW-1:0] hm_reg, hm_next, gm_reg, gm_next;
    logic hneg_reg, hneg_next, bneg_reg, bneg_next;
    logic [SQ_W-1:0] acc_reg, acc_next, v_reg, v_next, r_reg, r_next, bit_reg, bit_next;
    logic phase_reg, phase_next;
    logic [28:0] xm_reg, xm_next, ym_reg, ym_next;
    logic [29:0] len_reg, len_next;
    logic [RM_W-1:0] rem_reg, rem_next, dsh_reg, dsh_next;
    logic [15:0] q_reg, q_next, qx_reg, qx_next;
    logic out_v_reg, out_v_next;
    logic signed [spa_pkg::VEC_W-1:0] opx_reg, opx_next, opy_reg, opy_next;
    logic signed [spa_pkg::VEC_W-1:0] omx_reg, omx_next, omy_reg, omy_next;
    logic ovf_reg, ovf_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [32:0] dx, dy;
    logic [65:0] rnd_mag;
    logic signed [17:0] rnd_val;
    logic signed [SUM_W-1:0] h_val;
    logic [HW-1:0] nmax;
    logic [SQ_W-1:0] sq_t;
    logic [15:0] qc;
    logic signed [spa_pkg::VEC_W-1:0] qx_s, qy_s;

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result_valid = out_v_reg;
    assign principal_x = opx_reg;
    assign principal_y = opy_reg;
    assign minor_x = omx_reg;
    assign minor_y = omy_reg;
    assign overflowed = ovf_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MC:
            begin
                mul_a = $signed({17'b0, dist_reg});
                mul_b = flip_reg ? -cx_reg : cx_reg;
            end
            ST_MS:
            begin
                mul_a = $signed({17'b0, dist_reg});
                mul_b = flip_reg ? -cy_reg : cy_reg;
            end
            ST_MXX:
            begin
                mul_a = 33'(px_reg);
                mul_b = 33'(px_reg);
            end
            ST_MXY:
            begin
                mul_a = 33'(px_reg);
                mul_b = 33'(py_reg);
            end
            ST_MYY:
            begin
                mul_a = 33'(py_reg);
                mul_b = 33'(py_reg);
            end
            ST_SQ1:
            begin
                mul_a = $signed({6'b0, hm_reg[26:0]});
                mul_b = $signed({6'b0, hm_reg[26:0]});
            end
            ST_SQ2:
            begin
                if (phase_reg)
                begin
                    mul_a = $signed({4'b0, ym_reg});
                    mul_b = $signed({4'b0, ym_reg});
                end
                else
                begin
                    mul_a = $signed({6'b0, gm_reg[26:0]});
                    mul_b = $signed({6'b0, gm_reg[26:0]});
                end
            end
            ST_VEC:
            begin
                mul_a = $signed({4'b0, xm_next});
                mul_b = $signed({4'b0, xm_next});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dx = cy_reg >>> it_reg[3:0];
    assign dy = cx_reg >>> it_reg[3:0];
    assign rnd_mag = ((prod_reg < 0) ? 66'(-prod_reg) : 66'(prod_reg)) + (66'd1 <<< 29);
    assign rnd_val = (prod_reg < 0) ? -$signed(rnd_mag[47:30]) : $signed(rnd_mag[47:30]);
    assign h_val = sxx_reg - syy_reg;
    assign nmax = (hm_reg > gm_reg) ? hm_reg : gm_reg;
    assign sq_t = r_reg + bit_reg;
    assign qc = (q_reg > spa_pkg::UNIT_Q14) ? spa_pkg::UNIT_Q14 : q_reg;
    assign qx_s = bneg_reg ? -$signed(qx_reg) : $signed(qx_reg);
    assign qy_s = $signed(qc);

    always_comb
    begin
        state_next = state_reg;
        thr_next = thr_reg;
        dist_next = dist_reg;
        last_next = last_reg;
        flip_next = flip_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        z_next = z_reg;
        it_next = it_reg;
        px_next = px_reg;
        py_next = py_reg;
        sxx_next = sxx_reg;
        sxy_next = sxy_reg;
        syy_next = syy_reg;
        cnt_next = cnt_reg;
        drop_next = drop_reg;
        hm_next = hm_reg;
        gm_next = gm_reg;
        hneg_next = hneg_reg;
        bneg_next = bneg_reg;
        acc_next = acc_reg;
        v_next = v_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        phase_next = phase_reg;
        xm_next = xm_reg;
        ym_next = ym_reg;
        len_next = len_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next = q_reg;
        qx_next = qx_reg;
        out_v_next = 1'b0;
        opx_next = opx_reg;
        opy_next = opy_reg;
        omx_next = omx_reg;
        omy_next = omy_reg;
        ovf_next = ovf_reg;

        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dist_next = distance;
                    last_next = last_sample;
                    flip_next = bearing[15] ^ bearing[14];
                    cx_next = 33'sd652032874;
                    cy_next = '0;
                    z_next = spa_pkg::Z_W'($signed({bearing[15] ^ bearing[15] ^ bearing[14],
                                                    bearing[14:0], 8'b0}));
                    it_next = '0;
                    if (cnt_reg == CNT_W'(MAX_SAMPLES))
                    begin
                        drop_next = 1'b1;
                        state_next = last_sample ? ST_SOLV : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CORD;
                    end
                end
            end
            ST_CORD:
            begin
                if (z_reg >= 0)
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    z_next = z_reg - spa_pkg::atan_lookup(it_reg[3:0]);
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    z_next = z_reg + spa_pkg::atan_lookup(it_reg[3:0]);
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd15)
                begin
                    state_next = ST_MC;
                end
            end
            ST_MC:
            begin
                state_next = ST_MS;
            end
            ST_MS:
            begin
                px_next = rnd_val;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                py_next = rnd_val;
                state_next = ST_MXX;
            end
            ST_MXX:
            begin
                state_next = ST_MXY;
            end
            ST_MXY:
            begin
                sxx_next = sxx_reg + SUM_W'(prod_reg);
                state_next = ST_MYY;
            end
            ST_MYY:
            begin
                sxy_next = sxy_reg + SUM_W'(prod_reg);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                syy_next = syy_reg + SUM_W'(prod_reg);
                cnt_next = cnt_reg + CNT_W'(1);
                state_next = last_reg ? ST_SOLV : ST_IDLE;
            end
            ST_SOLV:
            begin
                hneg_next = h_val < 0;
                bneg_next = sxy_reg < 0;
                hm_next = HW'((h_val < 0) ? -h_val : h_val);
                gm_next = {SUM_W'((sxy_reg < 0) ? -sxy_reg : sxy_reg), 1'b0};
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (CW'(gm_reg[HW-1:1]) <= CW'(thr_reg))
                begin
                    if (hneg_reg)
                    begin
                        opx_next = '0;
                        opy_next = spa_pkg::UNIT_Q14;
                        omx_next = spa_pkg::UNIT_Q14;
                        omy_next = '0;
                    end
                    else
                    begin
                        opx_next = spa_pkg::UNIT_Q14;
                        opy_next = '0;
                        omx_next = '0;
                        omy_next = spa_pkg::UNIT_Q14;
                    end
                    ovf_next = drop_reg;
                    out_v_next = 1'b1;
                    sxx_next = '0;
                    sxy_next = '0;
                    syy_next = '0;
                    cnt_next = '0;
                    drop_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (|nmax[HW-1:27])
                begin
                    hm_next = hm_reg >> 1;
                    gm_next = gm_reg >> 1;
                end
                else if (!nmax[26])
                begin
                    hm_next = hm_reg << 1;
                    gm_next = gm_reg << 1;
                end
                else
                begin
                    state_next = ST_SQ1;
                end
            end
            ST_SQ1:
            begin
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                acc_next = SQ_W'(prod_reg);
                state_next = ST_SQ3;
            end
            ST_SQ3:
            begin
                v_next = acc_reg + SQ_W'(prod_reg);
                r_next = '0;
                bit_next = SQ_W'(1) << 58;
                it_next = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (v_reg >= sq_t)
                begin
                    v_next = v_reg - sq_t;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd29)
                begin
                    if (!phase_reg)
                    begin
                        state_next = ST_VEC;
                    end
                    else
                    begin
                        len_next = 30'(r_next);
                        state_next = ST_DVI;
                    end
                end
            end
            ST_VEC:
            begin
                if (hneg_reg)
                begin
                    xm_next = 29'(gm_reg[26:0]);
                    ym_next = 29'(r_reg[27:0]) + 29'(hm_reg[26:0]);
                end
                else
                begin
                    xm_next = 29'(hm_reg[26:0]) + 29'(r_reg[27:0]);
                    ym_next = 29'(gm_reg[26:0]);
                end
                phase_next = 1'b1;
                state_next = ST_SQ2;
            end
            ST_DVI:
            begin
                rem_next = {3'b0, xm_reg, 14'b0} + RM_W'(len_reg >> 1);
                dsh_next = RM_W'(len_reg) << 15;
                q_next = '0;
                it_next = '0;
                phase_next = 1'b0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    q_next = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[14:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                it_next = it_reg + 5'd1;
                if (it_reg == 5'd15)
                begin
                    it_next = '0;
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (phase_reg)
                begin
                    qx_next = qc;
                    rem_next = {3'b0, ym_reg, 14'b0} + RM_W'(len_reg >> 1);
                    dsh_next = RM_W'(len_reg) << 15;
                    q_next = '0;
                    phase_next = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    opx_next = qx_s;
                    opy_next = qy_s;
                    omx_next = bneg_reg ? qy_s : -qy_s;
                    omy_next = bneg_reg ? -qx_s : qx_s;
                    ovf_next = drop_reg;
                    out_v_next = 1'b1;
                    sxx_next = '0;
                    sxy_next = '0;
                    syy_next = '0;
                    cnt_next = '0;
                    drop_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg <= spa_pkg::THR_RESET;
            sxx_reg <= '0;
            sxy_reg <= '0;
            syy_reg <= '0;
            cnt_reg <= '0;
            drop_reg <= 1'b0;
            phase_reg <= 1'b0;
            it_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            thr_reg <= thr_next;
            sxx_reg <= sxx_next;
            sxy_reg <= sxy_next;
            syy_reg <= syy_next;
            cnt_reg <= cnt_next;
            drop_reg <= drop_next;
            phase_reg <= phase_next;
            it_reg <= it_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        last_reg <= last_next;
        flip_reg <= flip_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        z_reg <= z_next;
        prod_reg <= mul_p;
        px_reg <= px_next;
        py_reg <= py_next;
        hm_reg <= hm_next;
        gm_reg <= gm_next;
        hneg_reg <= hneg_next;
        bneg_reg <= bneg_next;
        acc_reg <= acc_next;
        v_reg <= v_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
        xm_reg <= xm_next;
        ym_reg <= ym_next;
        len_reg <= len_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg <= q_next;
        qx_reg <= qx_next;
        opx_reg <= opx_next;
        opy_reg <= opy_next;
        omx_reg <= omx_next;
        omy_reg <= omy_next;
        ovf_reg <= ovf_next;
    end

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_sample) |=> (busy || $past(cnt_reg) == CNT_W'(MAX_SAMPLES)))
        else $error("accepted item did not occupy the sequencer");

    a_y_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!principal_y[spa_pkg::VEC_W-1] && !minor_y[spa_pkg::VEC_W-1]))
        else $error("axis with negative y component");

    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cnt_reg == '0 && !drop_reg))
        else $error("scan state not cleared after result");

endmodule
